### sv/bap_pkg.sv
// Shared types and constants for the block-average pixelation block.
package bap_pkg;

    localparam int unsigned DEF_MAX_WIDTH  = 2048;
    localparam int unsigned DEF_MAX_HEIGHT = 2048;

    localparam int unsigned REG_W       = 12;
    localparam int unsigned CNT_W       = 11;
    localparam int unsigned PIX_W       = 8;
    localparam int unsigned SUM_W       = 30;
    localparam int unsigned POS_W       = 14;
    localparam int unsigned AREA_W      = 2 * REG_W;
    localparam int unsigned QUOT_W      = 8;
    localparam int unsigned DIV_W       = 32;
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned CFG_IDX_W   = 4;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_FRAME_WIDTH  = t_cfg_idx'(0);
    localparam t_cfg_idx REG_FRAME_HEIGHT = t_cfg_idx'(1);
    localparam t_cfg_idx REG_CELL_WIDTH   = t_cfg_idx'(2);
    localparam t_cfg_idx REG_CELL_HEIGHT  = t_cfg_idx'(3);

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [CNT_W-1:0] cell_column;
        logic [CNT_W-1:0] cell_row;
        logic [PIX_W-1:0] mean_red;
        logic [PIX_W-1:0] mean_green;
        logic [PIX_W-1:0] mean_blue;
        logic             frame_end;
    } t_cell;

    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
    } t_sums;

    // Clamped frame and cell sizes, all at least one.
    typedef struct packed {
        logic [REG_W-1:0] frame_width;
        logic [REG_W-1:0] frame_height;
        logic [REG_W-1:0] cell_width;
        logic [REG_W-1:0] cell_height;
    } t_dims;

    // A finished cell on its way from the accumulator to the divider.
    typedef struct packed {
        logic [CNT_W-1:0] cell_column;
        logic [CNT_W-1:0] cell_row;
        t_sums            sums;
        logic             frame_end;
    } t_job;

endpackage

### sv/bap_front.sv
// Pixel front end: raster position tracking and per-column running sums.
module bap_front
    import bap_pkg::*;
#(
    parameter int unsigned MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_restart,
    input  t_dims  i_dims,
    input  logic   i_push,
    input  t_pixel i_pixel,
    input  logic   i_q_afull,
    output logic   o_full,
    output logic   o_job_valid,
    output t_job   o_job
);

    localparam int unsigned ADDR_W = $clog2(MAX_WIDTH);

    logic [CNT_W-1:0] r_px, r_py, r_x_in, r_y_in, r_cell_x, r_band;
    logic [POS_W-1:0] r_start_x, r_start_y;

    logic              r_s1_valid, r_s1_first, r_s1_last, r_s1_fend;
    logic [ADDR_W-1:0] r_s1_addr;
    logic [CNT_W-1:0]  r_s1_col, r_s1_row;
    t_pixel            r_s1_pix;

    t_sums             mem [MAX_WIDTH];
    t_sums             r_rd;
    logic              r_fwd_valid;
    logic [ADDR_W-1:0] r_fwd_addr;
    t_sums             r_fwd_sums;

    logic             accept, in_range, at_first, at_last, frame_last;
    logic [POS_W-1:0] fw_p, fh_p, cw_p, ch_p;
    logic [ADDR_W-1:0] rd_addr;
    t_sums            base, sum_new;

    assign o_full = i_q_afull;
    assign accept = i_push && !o_full;

    assign fw_p = POS_W'(i_dims.frame_width);
    assign fh_p = POS_W'(i_dims.frame_height);
    assign cw_p = POS_W'(i_dims.cell_width);
    assign ch_p = POS_W'(i_dims.cell_height);

    // A cell is whole when its right and bottom edges stay inside the frame.
    assign in_range   = (r_start_x + cw_p <= fw_p) && (r_start_y + ch_p <= fh_p);
    assign frame_last = (r_start_x + (cw_p << 1) > fw_p) && (r_start_y + (ch_p << 1) > fh_p);
    assign at_first   = (r_x_in == '0) && (r_y_in == '0);
    assign at_last    = (REG_W'(r_x_in) == i_dims.cell_width - 1'b1)
                     && (REG_W'(r_y_in) == i_dims.cell_height - 1'b1);
    assign rd_addr    = ADDR_W'(r_cell_x);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_px      <= '0;
            r_py      <= '0;
            r_x_in    <= '0;
            r_y_in    <= '0;
            r_cell_x  <= '0;
            r_band    <= '0;
            r_start_x <= '0;
            r_start_y <= '0;
        end else if (accept) begin
            if (REG_W'(r_px) >= i_dims.frame_width - 1'b1) begin
                r_px      <= '0;
                r_x_in    <= '0;
                r_cell_x  <= '0;
                r_start_x <= '0;
                if (REG_W'(r_py) >= i_dims.frame_height - 1'b1) begin
                    r_py      <= '0;
                    r_y_in    <= '0;
                    r_band    <= '0;
                    r_start_y <= '0;
                end else begin
                    r_py <= r_py + 1'b1;
                    if (REG_W'(r_y_in) >= i_dims.cell_height - 1'b1) begin
                        r_y_in    <= '0;
                        r_band    <= r_band + 1'b1;
                        r_start_y <= r_start_y + ch_p;
                    end else begin
                        r_y_in <= r_y_in + 1'b1;
                    end
                end
            end else begin
                r_px <= r_px + 1'b1;
                if (REG_W'(r_x_in) >= i_dims.cell_width - 1'b1) begin
                    r_x_in    <= '0;
                    r_cell_x  <= r_cell_x + 1'b1;
                    r_start_x <= r_start_x + cw_p;
                end else begin
                    r_x_in <= r_x_in + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
        end else begin
            r_s1_valid <= accept && in_range;
            if (r_s1_valid) begin
                r_fwd_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_first <= at_first;
            r_s1_last  <= at_last;
            r_s1_fend  <= frame_last;
            r_s1_addr  <= rd_addr;
            r_s1_col   <= r_cell_x;
            r_s1_row   <= r_band;
            r_s1_pix   <= i_pixel;
        end
        if (r_s1_valid) begin
            r_fwd_addr <= r_s1_addr;
            r_fwd_sums <= sum_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rd <= mem[rd_addr];
        end
        if (r_s1_valid) begin
            mem[r_s1_addr] <= sum_new;
        end
    end

    // The most recent write may not be in the read data yet.
    always_comb begin
        base = (r_fwd_valid && r_fwd_addr == r_s1_addr) ? r_fwd_sums : r_rd;
        if (r_s1_first) begin
            sum_new.red   = SUM_W'(r_s1_pix.red);
            sum_new.green = SUM_W'(r_s1_pix.green);
            sum_new.blue  = SUM_W'(r_s1_pix.blue);
        end else begin
            sum_new.red   = SUM_W'(base.red + SUM_W'(r_s1_pix.red));
            sum_new.green = SUM_W'(base.green + SUM_W'(r_s1_pix.green));
            sum_new.blue  = SUM_W'(base.blue + SUM_W'(r_s1_pix.blue));
        end
    end

    assign o_job_valid       = r_s1_valid && r_s1_last;
    assign o_job.cell_column = r_s1_col;
    assign o_job.cell_row    = r_s1_row;
    assign o_job.sums        = sum_new;
    assign o_job.frame_end   = r_s1_fend;

endmodule

### sv/bap_queue.sv
// Short queue of finished cells between the accumulator and the divider.
module bap_queue
    import bap_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_valid,
    output t_job o_job,
    output logic o_afull
);

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned LVL_W = $clog2(QUEUE_DEPTH + 1);

    t_job             r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr, r_rdp;
    logic [LVL_W-1:0] r_count;

    assign o_valid = (r_count != '0);
    assign o_job   = r_slot[r_rdp];
    // One request may still be in flight in the accumulator.
    assign o_afull = (r_count >= LVL_W'(QUEUE_DEPTH - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rdp   <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rdp <= r_rdp + 1'b1;
            end
            r_count <= r_count + LVL_W'(i_push) - LVL_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_job;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && !i_pop && r_count == LVL_W'(QUEUE_DEPTH)))
        else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("queue underflow");
    a_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= LVL_W'(QUEUE_DEPTH))
        else $error("queue level out of range");

endmodule

### sv/bap_back.sv
// Back end: iterative division of the three cell sums by the cell area.
module bap_back
    import bap_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [AREA_W-1:0] i_area,
    input  logic              i_job_valid,
    input  t_job              i_job,
    output logic              o_job_pop,
    output logic              o_empty,
    input  logic              i_pop,
    output t_cell             o_cell
);

    localparam int unsigned STEP_W = $clog2(QUOT_W);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_HOLD = 3'b100
    } t_state;

    t_state            r_state;
    logic [STEP_W-1:0] r_step;
    logic [DIV_W-1:0]  r_rem  [3];
    logic [QUOT_W-1:0] r_quot [3];
    logic [CNT_W-1:0]  r_col, r_row;
    logic              r_fend;

    logic [STEP_W-1:0] bit_pos;
    logic [DIV_W-1:0]  divisor;

    assign o_job_pop = (r_state == ST_IDLE) && i_job_valid;
    assign o_empty   = (r_state != ST_HOLD);
    assign bit_pos   = STEP_W'(QUOT_W - 1) - r_step;
    assign divisor   = DIV_W'(i_area) << bit_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_job_valid) begin
                        r_state <= ST_DIV;
                        r_step  <= '0;
                    end
                end
                ST_DIV: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_W'(QUOT_W - 1)) begin
                        r_state <= ST_HOLD;
                    end
                end
                ST_HOLD: begin
                    if (i_pop) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Restoring division, one quotient bit per cycle, most significant first.
    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_rem[0] <= DIV_W'(i_job.sums.red);
            r_rem[1] <= DIV_W'(i_job.sums.green);
            r_rem[2] <= DIV_W'(i_job.sums.blue);
            for (int c = 0; c < 3; c++) begin
                r_quot[c] <= '0;
            end
            r_col  <= i_job.cell_column;
            r_row  <= i_job.cell_row;
            r_fend <= i_job.frame_end;
        end else if (r_state == ST_DIV) begin
            for (int c = 0; c < 3; c++) begin
                if (r_rem[c] >= divisor) begin
                    r_rem[c]           <= r_rem[c] - divisor;
                    r_quot[c][bit_pos] <= 1'b1;
                end
            end
        end
    end

    assign o_cell.cell_column = r_col;
    assign o_cell.cell_row    = r_row;
    assign o_cell.mean_red    = r_quot[0];
    assign o_cell.mean_green  = r_quot[1];
    assign o_cell.mean_blue   = r_quot[2];
    assign o_cell.frame_end   = r_fend;

    a_hold_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_HOLD && !i_pop) |=> (r_state == ST_HOLD && $stable(o_cell)))
        else $error("waiting result changed");
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && r_step == STEP_W'(QUOT_W - 1)) |=> r_state == ST_HOLD)
        else $error("division did not finish in time");
    a_area_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DIV |-> i_area != '0)
        else $error("zero cell area during division");

endmodule

### sv/block_average_pixelate.sv
// Top level of the block-average pixelation block.
// Pixels enter in raster order at up to one per clock; a two-stage read-modify-write
// accumulator keeps one red, green and blue sum per cell column of the current band and
// hands each finished cell to a four-entry queue. A shared restoring divider then forms the
// three means one quotient bit at a time and takes the next cell only after its result is
// popped; the pixel side stalls when the queue is one entry short of full.
// A write to any of the four size registers restarts the frame position.
module block_average_pixelate
    import bap_pkg::*;
#(
    parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             push,
    output logic             full,
    input  t_pixel           i_pixel,
    output logic             empty,
    input  logic             pop,
    output t_cell            o_cell,
    input  logic             i_cfg_we,
    input  t_cfg_idx         i_cfg_idx,
    input  logic [REG_W-1:0] i_cfg_data
);

    logic [REG_W-1:0]  r_frame_width, r_frame_height, r_cell_width, r_cell_height;
    logic [AREA_W-1:0] r_area;
    logic              restart;
    t_dims             dims;

    logic q_push, q_valid, q_pop, q_afull;
    t_job front_job, q_job;

    function automatic logic [REG_W-1:0] clamp_dim(input logic [REG_W-1:0] v,
                                                   input int unsigned lim);
        logic [REG_W-1:0] res;
        if (v == '0) begin
            res = REG_W'(1);
        end else if (32'(v) > lim) begin
            res = REG_W'(lim);
        end else begin
            res = v;
        end
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= REG_W'(64);
            r_frame_height <= REG_W'(64);
            r_cell_width   <= REG_W'(16);
            r_cell_height  <= REG_W'(16);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                REG_CELL_WIDTH:   r_cell_width   <= i_cfg_data;
                REG_CELL_HEIGHT:  r_cell_height  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign restart = i_cfg_we && (i_cfg_idx == REG_FRAME_WIDTH || i_cfg_idx == REG_FRAME_HEIGHT
                  || i_cfg_idx == REG_CELL_WIDTH || i_cfg_idx == REG_CELL_HEIGHT);

    assign dims.frame_width  = clamp_dim(r_frame_width, MAX_WIDTH);
    assign dims.frame_height = clamp_dim(r_frame_height, MAX_HEIGHT);
    assign dims.cell_width   = clamp_dim(r_cell_width, MAX_WIDTH);
    assign dims.cell_height  = clamp_dim(r_cell_height, MAX_HEIGHT);

    always_ff @(posedge i_clk) begin
        r_area <= AREA_W'(dims.cell_width) * AREA_W'(dims.cell_height);
    end

    bap_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_restart   (restart),
        .i_dims      (dims),
        .i_push      (push),
        .i_pixel     (i_pixel),
        .i_q_afull   (q_afull),
        .o_full      (full),
        .o_job_valid (q_push),
        .o_job       (front_job)
    );

    bap_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (q_job),
        .o_afull (q_afull)
    );

    bap_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_area      (r_area),
        .i_job_valid (q_valid),
        .i_job       (q_job),
        .o_job_pop   (q_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_cell      (o_cell)
    );

endmodule

### verif/block_average_pixelate_tb.sv
// Self-checking testbench for block_average_pixelate: directed and random pixel streams.
module block_average_pixelate_tb;
    import bap_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int HOLD_AT_CELL   = 8;
    localparam int HOLD_CYCLES    = 400;
    localparam t_cfg_idx REG_UNUSED = t_cfg_idx'(15);

    typedef struct {
        t_pixel px;
        bit     typed;
        t_cell  want;
    } t_row;

    logic             i_clk = 0;
    logic             i_rst_n = 0;
    logic             push = 0;
    logic             full;
    t_pixel           i_pixel = '0;
    logic             empty;
    logic             pop = 0;
    t_cell            o_cell;
    logic             i_cfg_we = 0;
    t_cfg_idx         i_cfg_idx = '0;
    logic [REG_W-1:0] i_cfg_data = '0;

    block_average_pixelate uut (.*);

    always #4 i_clk = ~i_clk;

    // Predictor state.
    logic [REG_W-1:0] reg_fw = REG_W'(64), reg_fh = REG_W'(64);
    logic [REG_W-1:0] reg_cw = REG_W'(16), reg_ch = REG_W'(16);
    int unsigned pos_x, pos_y, in_x, in_y, col_idx, row_idx;
    logic [SUM_W-1:0] red_acc [DEF_MAX_WIDTH];
    logic [SUM_W-1:0] grn_acc [DEF_MAX_WIDTH];
    logic [SUM_W-1:0] blu_acc [DEF_MAX_WIDTH];

    t_cell cells_due [$];
    int    errors = 0;
    int    idle_cycles = 0;
    int    cells_popped = 0;
    bit    no_gaps = 0;

    function automatic int unsigned eff_size(int unsigned v, int unsigned lim);
        if (v == 0) return 1;
        if (v > lim) return lim;
        return v;
    endfunction

    function automatic void restart_frame();
        pos_x = 0; pos_y = 0; in_x = 0; in_y = 0; col_idx = 0; row_idx = 0;
    endfunction

    function automatic void average_pixel(t_pixel px, output bit got, output t_cell c);
        int unsigned fw, fh, cw, ch, nx, ny, area;
        fw = eff_size(32'(reg_fw), DEF_MAX_WIDTH);
        fh = eff_size(32'(reg_fh), DEF_MAX_HEIGHT);
        cw = eff_size(32'(reg_cw), DEF_MAX_WIDTH);
        ch = eff_size(32'(reg_ch), DEF_MAX_HEIGHT);
        nx = fw / cw;
        ny = fh / ch;
        got = 0;
        c = '0;
        if (pos_x < nx * cw && pos_y < ny * ch && col_idx < DEF_MAX_WIDTH) begin
            if (in_x == 0 && in_y == 0) begin
                red_acc[col_idx] = SUM_W'(px.red);
                grn_acc[col_idx] = SUM_W'(px.green);
                blu_acc[col_idx] = SUM_W'(px.blue);
            end else begin
                red_acc[col_idx] = red_acc[col_idx] + SUM_W'(px.red);
                grn_acc[col_idx] = grn_acc[col_idx] + SUM_W'(px.green);
                blu_acc[col_idx] = blu_acc[col_idx] + SUM_W'(px.blue);
            end
            if (in_x == cw - 1 && in_y == ch - 1) begin
                area = cw * ch;
                got = 1;
                c.cell_column = CNT_W'(col_idx);
                c.cell_row    = CNT_W'(row_idx);
                c.mean_red    = PIX_W'(red_acc[col_idx] / area);
                c.mean_green  = PIX_W'(grn_acc[col_idx] / area);
                c.mean_blue   = PIX_W'(blu_acc[col_idx] / area);
                c.frame_end   = (col_idx == nx - 1 && row_idx == ny - 1);
            end
        end
        if (pos_x >= fw - 1) begin
            pos_x = 0; in_x = 0; col_idx = 0;
            if (pos_y >= fh - 1) begin
                pos_y = 0; in_y = 0; row_idx = 0;
            end else begin
                pos_y = (pos_y + 1) & 'h7FF;
                if (in_y >= ch - 1) begin
                    in_y = 0;
                    row_idx = (row_idx + 1) & 'h7FF;
                end else begin
                    in_y = (in_y + 1) & 'h7FF;
                end
            end
        end else begin
            pos_x = (pos_x + 1) & 'h7FF;
            if (in_x >= cw - 1) begin
                in_x = 0;
                col_idx = (col_idx + 1) & 'h7FF;
            end else begin
                in_x = (in_x + 1) & 'h7FF;
            end
        end
    endfunction

    // Offers one pixel; push stays high between back-to-back requests.
    task automatic send_pixel(t_pixel px, bit typed = 0, t_cell typed_cell = '0);
        int    gap;
        bit    got;
        t_cell c;
        gap = no_gaps ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            push <= 0;
            repeat (gap) @(posedge i_clk);
        end
        push <= 1;
        i_pixel <= px;
        do @(posedge i_clk); while (full);
        average_pixel(px, got, c);
        if (typed) cells_due.insert(cells_due.size(), typed_cell);
        else if (got) cells_due.insert(cells_due.size(), c);
    endtask

    task automatic end_burst();
        push <= 0;
        while (cells_due.size() != 0) @(posedge i_clk);
        // A dropped pixel may still be in the accumulator after the last result.
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [REG_W-1:0] data);
        i_cfg_we   <= 1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 0;
        case (idx)
            REG_FRAME_WIDTH:  begin reg_fw = data; restart_frame(); end
            REG_FRAME_HEIGHT: begin reg_fh = data; restart_frame(); end
            REG_CELL_WIDTH:   begin reg_cw = data; restart_frame(); end
            REG_CELL_HEIGHT:  begin reg_ch = data; restart_frame(); end
            default: ;
        endcase
    endtask

    task automatic set_geometry(int fw, int fh, int cw, int ch);
        write_reg(REG_FRAME_WIDTH, REG_W'(fw));
        write_reg(REG_FRAME_HEIGHT, REG_W'(fh));
        write_reg(REG_CELL_WIDTH, REG_W'(cw));
        write_reg(REG_CELL_HEIGHT, REG_W'(ch));
    endtask

    function automatic t_pixel random_pixel();
        t_pixel px;
        px = (3 * PIX_W)'($urandom);
        case ($urandom_range(0, 9))
            0: px = '0;
            1: px = '1;
            default: ;
        endcase
        return px;
    endfunction

    // Receiver: random pop gaps, and one long hold-off so the block backs up.
    // The hold-off lands in the single-pixel-cell section, where every pixel is a result.
    initial begin
        int gap;
        wait (i_rst_n);
        forever begin
            gap = no_gaps ? 0 : $urandom_range(0, 6);
            if (cells_popped == HOLD_AT_CELL) gap = HOLD_CYCLES;
            if (gap > 0) begin
                pop <= 0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1;
            do @(posedge i_clk); while (empty);
            cells_popped++;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (cells_due.size() == 0) begin
                $display("%0t: unexpected cell %p", $time, o_cell);
                errors++;
            end else begin
                if (o_cell !== cells_due[0]) begin
                    $display("%0t: cell mismatch, expected %p, actual %p",
                             $time, cells_due[0], o_cell);
                    errors++;
                end
                void'(cells_due.pop_front());
            end
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        t_row rows [$];
        t_row r;
        t_cell w;
        int fw, fh, cw, ch;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Sizes after reset: the first rows of the default frame, where no cell finishes yet.
        for (int i = 0; i < 80; i++) send_pixel(random_pixel());
        end_burst();

        // A 2x2 frame that is one 2x2 cell: all-white, all-black, then mixed.
        set_geometry(2, 2, 2, 2);
        w = '{cell_column: 0, cell_row: 0, mean_red: 255, mean_green: 255,
              mean_blue: 255, frame_end: 1};
        for (int i = 0; i < 4; i++) begin
            r.px = '1; r.typed = (i == 3); r.want = w;
            rows.insert(rows.size(), r);
        end
        w.mean_red = 0; w.mean_green = 0; w.mean_blue = 0;
        for (int i = 0; i < 4; i++) begin
            r.px = '0; r.typed = (i == 3); r.want = w;
            rows.insert(rows.size(), r);
        end
        for (int i = 0; i < 8; i++) begin
            r.px = random_pixel(); r.typed = 0; r.want = '0;
            rows.insert(rows.size(), r);
        end
        foreach (rows[i]) send_pixel(rows[i].px, rows[i].typed, rows[i].want);
        end_burst();

        // Unused register index changes nothing, frame continues.
        write_reg(REG_UNUSED, '1);
        for (int i = 0; i < 4; i++) send_pixel(random_pixel());
        end_burst();

        // Cell wider than the frame: nothing ever completes.
        set_geometry(3, 2, 4, 1);
        for (int i = 0; i < 12; i++) send_pixel(random_pixel());
        end_burst();

        // Zero registers act as one: every pixel is its own cell.
        set_geometry(0, 0, 0, 0);
        for (int i = 0; i < 40; i++) send_pixel(random_pixel());
        end_burst();

        // Oversized frame width clamps to the maximum; single-pixel cells along the row.
        set_geometry(4095, 1, 1, 1);
        for (int i = 0; i < 40; i++) send_pixel(random_pixel());
        end_burst();

        // Random geometries, some with trailing partial cells and mid-frame restarts.
        for (int p = 0; p < 10; p++) begin
            fw = $urandom_range(1, 12);
            fh = $urandom_range(1, 8);
            cw = $urandom_range(1, fw + 1);
            ch = $urandom_range(1, fh);
            no_gaps = ($urandom_range(0, 3) == 0);
            set_geometry(fw, fh, cw, ch);
            for (int i = 0; i < 35; i++) send_pixel(random_pixel());
            end_burst();
        end

        if (errors == 0 && cells_due.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
